// ===== rtl/prime_table_totient_mobius_unit_assert.svh =====
// assertion macros for the prime table unit
// used by prime_table_totient_mobius_unit only
`ifndef PRIME_TABLE_TOTIENT_MOBIUS_UNIT_ASSERT_SVH
`define PRIME_TABLE_TOTIENT_MOBIUS_UNIT_ASSERT_SVH

// clocked check, masked during reset
`define PTM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never hold, masked during reset
`define PTM_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== rtl/ptm_pkg.sv =====
// shared types and codes for the prime table unit
// no dependencies
package ptm_pkg;

   localparam logic       REQ_BUILD = 1'b0;
   localparam logic       REQ_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BUILT    = 2'd1;
   localparam logic [1:0] STATUS_NOTREADY = 2'd2;

   typedef struct packed {
      logic        start;
      logic [15:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_rsp_type;

endpackage

// ===== rtl/ptm_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on ptm_pkg
module ptm_div
   import ptm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [16:0] trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[15]} - {1'b0, dvs_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!trial[16]) begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = {rem_ff[14:0], quo_ff[15]};
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== rtl/prime_table_totient_mobius_unit.sv =====
// prime table unit: sieve build, totient and mobius queries
// depends on ptm_pkg, ptm_div and the assertion macro header
//
// request channel: req_valid, req_stall, req_type, req_query_value.
// result channel: rsp_valid, rsp_stall and one port per result field.
// every request beat yields exactly one result beat, in order.
// one table of largest prime divisors sits in a synchronous memory with one
// write port and one read port; a value is prime when its entry equals itself.
// build: a clearing pass over min(TABLE_SIZE, 65536) entries, then a
// sieve that reads each candidate once and writes one multiple per cycle.
// query: for each prime factor with multiplicity, a table read, a divide
// and a multiply; a query before any build or beyond the table skips the
// table and goes straight to the done state.
// reset empties the table state: queries answer not-ready until a build.
// the result register holds while rsp_stall is high; a new request is taken
// only when the sequencer is idle.
module prime_table_totient_mobius_unit
   import ptm_pkg::*;
#(
   parameter int TABLE_SIZE = 65536
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [15:0] req_query_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_totient,
   output logic signed [1:0] rsp_mobius,
   output logic [15:0] rsp_largest_prime_factor,
   output logic        rsp_is_prime
);

`include "prime_table_totient_mobius_unit_assert.svh"

   localparam logic [16:0] LIMIT = 17'((TABLE_SIZE < 65536) ? TABLE_SIZE : 65536);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLEAR = 4'd1;
   localparam logic [3:0] ST_S_RD  = 4'd2;
   localparam logic [3:0] ST_S_CHK = 4'd3;
   localparam logic [3:0] ST_MARK  = 4'd4;
   localparam logic [3:0] ST_Q_RD  = 4'd5;
   localparam logic [3:0] ST_Q_CHK = 4'd6;
   localparam logic [3:0] ST_Q_DIV = 4'd7;
   localparam logic [3:0] ST_Q_MUL = 4'd8;
   localparam logic [3:0] ST_DONE  = 4'd9;

   logic [15:0] mem [65536];
   logic [15:0] rd_data_ff;
   logic        mem_we;
   logic [15:0] mem_wa, mem_wd, mem_ra;

   logic [3:0]  state_ff, state_in;
   logic        ready_ff, ready_in;
   logic [16:0] p_ff, p_in;
   logic [16:0] m_ff, m_in;
   logic [16:0] m_next;
   logic [15:0] n_ff, n_in;
   logic [15:0] rest_ff, rest_in;
   logic [15:0] fac_ff, fac_in;
   logic [15:0] prev_ff, prev_in;
   logic [15:0] mulop_ff, mulop_in;
   logic [15:0] phi_ff, phi_in;
   logic [31:0] product;
   logic        neg_ff, neg_in;
   logic        sq_ff, sq_in;
   logic        first_ff, first_in;
   logic [15:0] lpf_ff, lpf_in;
   logic        prime_ff, prime_in;
   logic [1:0]  stat_ff, stat_in;

   logic        ov_ff, ov_in;
   logic [1:0]  o_status_ff, o_status_in;
   logic [15:0] o_tot_ff, o_tot_in;
   logic [1:0]  o_mob_ff, o_mob_in;
   logic [15:0] o_lpf_ff, o_lpf_in;
   logic        o_prime_ff, o_prime_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   ptm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign m_next    = m_ff + p_ff;
   assign product   = mulop_ff * phi_ff;

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      p_in     = p_ff;
      m_in     = m_ff;
      n_in     = n_ff;
      rest_in  = rest_ff;
      fac_in   = fac_ff;
      prev_in  = prev_ff;
      mulop_in = mulop_ff;
      phi_in   = phi_ff;
      neg_in   = neg_ff;
      sq_in    = sq_ff;
      first_in = first_ff;
      lpf_in   = lpf_ff;
      prime_in = prime_ff;
      stat_in  = stat_ff;
      mem_we   = 1'b0;
      mem_wa   = m_ff[15:0];
      mem_wd   = p_ff[15:0];
      mem_ra   = rest_ff;
      div_req.start    = 1'b0;
      div_req.dividend = rest_ff;
      div_req.divisor  = fac_ff;

      ov_in       = ov_ff && rsp_stall;
      o_status_in = o_status_ff;
      o_tot_in    = o_tot_ff;
      o_mob_in    = o_mob_ff;
      o_lpf_in    = o_lpf_ff;
      o_prime_in  = o_prime_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               phi_in   = 16'd1;
               neg_in   = 1'b0;
               sq_in    = 1'b0;
               first_in = 1'b1;
               prev_in  = '0;
               lpf_in   = '0;
               prime_in = 1'b0;
               n_in     = req_query_value;
               rest_in  = req_query_value;
               if (req_type == REQ_BUILD) begin
                  m_in     = '0;
                  stat_in  = STATUS_BUILT;
                  state_in = ST_CLEAR;
               end else if (!ready_ff || {1'b0, req_query_value} >= LIMIT) begin
                  stat_in  = STATUS_NOTREADY;
                  state_in = ST_DONE;
               end else begin
                  stat_in  = STATUS_OK;
                  state_in = ST_Q_RD;
               end
            end
         end
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wd = '0;
            m_in   = m_ff + 17'd1;
            if (m_ff == LIMIT - 17'd1) begin
               p_in     = 17'd2;
               state_in = ST_S_RD;
            end
         end
         ST_S_RD: begin
            mem_ra = p_ff[15:0];
            if (p_ff >= LIMIT) begin
               ready_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_S_CHK;
            end
         end
         ST_S_CHK: begin
            if (rd_data_ff == '0) begin
               m_in     = p_ff;
               state_in = ST_MARK;
            end else begin
               p_in     = p_ff + 17'd1;
               state_in = ST_S_RD;
            end
         end
         ST_MARK: begin
            mem_we = 1'b1;
            m_in   = m_next;
            if (m_next >= LIMIT) begin
               p_in     = p_ff + 17'd1;
               state_in = ST_S_RD;
            end
         end
         ST_Q_RD: begin
            state_in = ST_Q_CHK;
         end
         ST_Q_CHK: begin
            first_in = 1'b0;
            if (first_ff) begin
               lpf_in   = rd_data_ff;
               prime_in = (rd_data_ff == n_ff) && (rd_data_ff != '0);
            end
            fac_in = rd_data_ff;
            if (rest_ff < 16'd2 || rd_data_ff < 16'd2) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_Q_DIV;
            end
         end
         ST_Q_DIV: begin
            if (!first_ff) begin
               div_req.start = 1'b1;
               first_in      = 1'b1;
            end
            if (div_rsp.done) begin
               first_in = 1'b0;
               rest_in  = div_rsp.quotient;
               prev_in  = fac_ff;
               if (fac_ff == prev_ff) begin
                  mulop_in = fac_ff;
                  sq_in    = 1'b1;
               end else begin
                  mulop_in = fac_ff - 16'd1;
                  neg_in   = !neg_ff;
               end
               state_in = ST_Q_MUL;
            end
         end
         ST_Q_MUL: begin
            phi_in   = product[15:0];
            state_in = ST_Q_RD;
         end
         ST_DONE: begin
            if (!ov_ff || !rsp_stall) begin
               ov_in       = 1'b1;
               o_status_in = stat_ff;
               if (stat_ff == STATUS_OK) begin
                  o_tot_in   = phi_ff;
                  o_mob_in   = sq_ff ? 2'b00 : (neg_ff ? 2'b11 : 2'b01);
                  o_lpf_in   = lpf_ff;
                  o_prime_in = prime_ff;
               end else begin
                  o_tot_in   = '0;
                  o_mob_in   = '0;
                  o_lpf_in   = '0;
                  o_prime_in = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         ov_ff    <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         ov_ff    <= ov_in;
         first_ff <= first_in;
      end
      p_ff        <= p_in;
      m_ff        <= m_in;
      n_ff        <= n_in;
      rest_ff     <= rest_in;
      fac_ff      <= fac_in;
      prev_ff     <= prev_in;
      mulop_ff    <= mulop_in;
      phi_ff      <= phi_in;
      neg_ff      <= neg_in;
      sq_ff       <= sq_in;
      lpf_ff      <= lpf_in;
      prime_ff    <= prime_in;
      stat_ff     <= stat_in;
      o_status_ff <= o_status_in;
      o_tot_ff    <= o_tot_in;
      o_mob_ff    <= o_mob_in;
      o_lpf_ff    <= o_lpf_in;
      o_prime_ff  <= o_prime_in;
   end

   assign rsp_valid                = ov_ff;
   assign rsp_status               = o_status_ff;
   assign rsp_totient              = o_tot_ff;
   assign rsp_mobius               = o_mob_ff;
   assign rsp_largest_prime_factor = o_lpf_ff;
   assign rsp_is_prime             = o_prime_ff;

   `PTM_ASSERT(a_take_only_idle, (req_valid && !req_stall) |=> (state_ff != ST_IDLE),
      "request taken while busy")
   `PTM_NEVER(a_status_code, rsp_valid && (rsp_status == 2'd3), "bad status code")
   `PTM_ASSERT(a_built_ready, (rsp_valid && rsp_status == STATUS_BUILT) |-> ready_ff,
      "build answered before table ready")
   `PTM_ASSERT(a_zero_fields, (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_totient == '0),
      "nonzero totient on non-query result")

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for prime_table_totient_mobius_unit
// predicts totient, mobius, largest prime factor and primality from its own sieve
// depends on ptm_pkg and the unit rtl
module testbench;
   import ptm_pkg::*;

   typedef struct {
      logic [1:0]        status;
      logic [15:0]       totient;
      logic signed [1:0] mobius;
      logic [15:0]       lpf;
      logic              prime;
   } answer_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_type;
   logic [15:0]       req_query_value;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [1:0]        rsp_status;
   logic [15:0]       rsp_totient;
   logic signed [1:0] rsp_mobius;
   logic [15:0]       rsp_largest_prime_factor;
   logic              rsp_is_prime;

   logic [15:0] divisor_of [0:65535];
   logic        table_built;
   answer_type  pending_answers[$];
   int          idle_pct;
   int          stall_pct;
   int          errors;

   prime_table_totient_mobius_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_type(req_type), .req_query_value(req_query_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_totient(rsp_totient),
      .rsp_mobius(rsp_mobius),
      .rsp_largest_prime_factor(rsp_largest_prime_factor),
      .rsp_is_prime(rsp_is_prime)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #50_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // largest prime divisor of every value below 65536
   task automatic run_sieve();
      int p;
      int m;
      for (int v = 0; v < 65536; v++) divisor_of[v] = 16'd0;
      for (p = 2; p < 65536; p++) begin
         if (divisor_of[p] == 16'd0) begin
            for (m = p; m < 65536; m += p) divisor_of[m] = p[15:0];
         end
      end
   endtask

   function automatic answer_type factor_value(logic kind, logic [15:0] value);
      answer_type  a;
      int unsigned rest;
      int unsigned phi;
      int unsigned p;
      int unsigned q;
      int          mu;
      bit          squared;
      a = '{status: STATUS_OK, totient: 16'd0, mobius: 2'sd0, lpf: 16'd0, prime: 1'b0};
      if (kind == REQ_BUILD) begin
         a.status = STATUS_BUILT;
         return a;
      end
      if (!table_built) begin
         a.status = STATUS_NOTREADY;
         return a;
      end
      phi = 1;
      mu = 1;
      squared = 0;
      rest = 32'(value);
      while (rest > 1) begin
         p = 32'(divisor_of[rest[15:0]]);
         if (p < 2) break;
         q = p - 1;
         rest = rest / p;
         if (rest % p == 0) squared = 1;
         while (rest % p == 0) begin
            q = q * p;
            rest = rest / p;
         end
         phi = phi * q;
         mu = -mu;
      end
      if (squared) mu = 0;
      a.totient = phi[15:0];
      a.mobius = mu[1:0];
      a.lpf = divisor_of[value];
      a.prime = (value >= 16'd2) && (divisor_of[value] == value);
      return a;
   endfunction

   task automatic send_beat(logic kind, logic [15:0] value);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_query_value <= value;
      do @(posedge clock); while (req_stall);
      if (kind == REQ_BUILD) table_built = 1'b1;
      pending_answers.push_back(factor_value(kind, value));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("unexpected result beat");
            errors++;
         end else begin
            e = pending_answers.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_totient !== e.totient) begin
               $error("totient expected %0d actual %0d", e.totient, rsp_totient);
               errors++;
            end
            if (rsp_mobius !== e.mobius) begin
               $error("mobius expected %0d actual %0d", e.mobius, rsp_mobius);
               errors++;
            end
            if (rsp_largest_prime_factor !== e.lpf) begin
               $error("largest_prime_factor expected %0d actual %0d",
                      e.lpf, rsp_largest_prime_factor);
               errors++;
            end
            if (rsp_is_prime !== e.prime) begin
               $error("is_prime expected %0d actual %0d", e.prime, rsp_is_prime);
               errors++;
            end
         end
      end
   end

   task automatic test_query_before_build();
      send_beat(REQ_QUERY, 16'd0);
      send_beat(REQ_QUERY, 16'd7);
      send_beat(REQ_QUERY, 16'hFFFF);
   endtask

   task automatic test_first_build();
      send_beat(REQ_BUILD, 16'hA5A5);
   endtask

   task automatic test_corner_queries();
      logic [15:0] corners[] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd9, 16'd12,
         16'd30030, 16'd32768, 16'd49, 16'd65521, 16'd65534, 16'd65535,
         16'd65025, 16'd46189, 16'd510};
      foreach (corners[i]) send_beat(REQ_QUERY, corners[i]);
   endtask

   // rebuild from idle, with the sender holding off until all results are in
   task automatic test_rebuild();
      drain();
      send_beat(REQ_BUILD, 16'h0000);
      drain();
      send_beat(REQ_QUERY, 16'd65521);
   endtask

   task automatic test_random_queries();
      int idles[4] = '{0, 63, 0, 34};
      int stalls[4] = '{0, 0, 63, 34};
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idles[ph];
         stall_pct = stalls[ph];
         for (int i = 0; i < 108; i++) begin
            if ($urandom_range(0, 3) == 0) send_beat(REQ_QUERY, 16'($urandom_range(0, 300)));
            else send_beat(REQ_QUERY, 16'($urandom_range(0, 65535)));
         end
      end
      idle_pct = 0;
      stall_pct = 0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_QUERY;
      req_query_value = 16'd0;
      table_built = 1'b0;
      idle_pct = 0;
      stall_pct = 0;
      errors = 0;
      run_sieve();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_query_before_build();
      test_first_build();
      test_corner_queries();
      test_rebuild();
      test_random_queries();
      drain();
      repeat (400) @(posedge clock);
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ptm_pkg.sv
rtl/ptm_div.sv
rtl/prime_table_totient_mobius_unit.sv
sim/testbench.sv
